// ----- hdl/jmpr_pkg.sv -----
// Package for the joypad multiplexer and command packet receiver.
// Holds the shared item types, controller state and command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jmpr_pkg;

    // Packet geometry
    localparam int PACKET_BYTES = 16;
    localparam int BYTE_IDX_W   = $clog2(PACKET_BYTES);
    localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_INDEX = BYTE_IDX_W'(PACKET_BYTES - 1);

    // Pad registers on the configuration port
    localparam int PAD_COUNT = 4;
    localparam int PAD_IDX_W = $clog2(PAD_COUNT);

    localparam logic [PAD_IDX_W-1:0] REG_PAD_ONE   = 2'd0;
    localparam logic [PAD_IDX_W-1:0] REG_PAD_TWO   = 2'd1;
    localparam logic [PAD_IDX_W-1:0] REG_PAD_THREE = 2'd2;
    localparam logic [PAD_IDX_W-1:0] REG_PAD_FOUR  = 2'd3;

    localparam logic [7:0] PAD_RESET = 8'hff;

    // Multiplayer modes (2 and 3 both mean four players)
    localparam logic [1:0] MODE_ONE = 2'd0;
    localparam logic [1:0] MODE_TWO = 2'd1;

    // Player id forced by the multiplayer command
    localparam logic [1:0] PLAYER_AFTER_CMD = 2'd3;

    // Command code sits in byte 0 bits 7..3
    localparam logic [4:0] MULTI_CMD = 5'h11;

    localparam logic [3:0] NIBBLE_ALL = 4'hf;

    typedef struct packed {
        logic select_dpad;
        logic select_buttons;
    } in_item_t;

    typedef struct packed {
        logic [3:0]            joypad_nibble;
        logic [1:0]            current_player;
        logic [1:0]            player_mode;
        logic                  byte_valid;
        logic [7:0]            packet_byte;
        logic [BYTE_IDX_W-1:0] byte_index;
        logic                  last;
    } out_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // take the input item and update the receiver
        logic next_byte; // step to the next packet byte
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic final_result; // the result on show is the last of this item
    } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/joypad_mux_packet_receiver.sv -----
// Top level of the joypad multiplexer with command packet receiver.
// Depends on jmpr_pkg, jmpr_controller and jmpr_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one transfer is one write of
//   the p14/p15 select lines. Output channel (out_valid / out_stall /
//   out_data): result items with the joypad nibble, player id, mode and,
//   for a completed packet, one packet byte each.
//   Configuration: cfg_write with cfg_index 0..3 loads pad registers 1..4;
//   write only while the block is idle.
//   Timing: the first result is valid the cycle after the input transfer.
//   An ordinary write gives one result. The stop bit of a good packet gives
//   16 results, one byte per cycle while the receiver does not stall, from
//   the packet store's single read port.
//   One item is handled at a time; in_stall stays high until the last
//   result of the current item has been taken.
//   Reset: pads read 0xff, player 0, single-player mode, receiver waiting
//   for a reset pulse. While out_stall is high the result on show holds.
`timescale 1ns / 1ps
`default_nettype none

module joypad_mux_packet_receiver
    import jmpr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_item_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_item_t                 out_data,
    input  wire logic                 cfg_write,
    input  wire logic [PAD_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    jmpr_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    jmpr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .out_data  (out_data),
        .status    (status)
    );

endmodule

`default_nettype wire

// ----- hdl/jmpr_datapath.sv -----
// Datapath: pad registers, player select, serial packet receiver and packet store.
// Depends on jmpr_pkg; driven by jmpr_controller through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module jmpr_datapath
    import jmpr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [PAD_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire in_item_t             in_data,
    input  wire dp_cmd_t              cmd,
    output out_item_t                 out_data,
    output dp_status_t                status
);

    logic [7:0] pads_reg [PAD_COUNT];

    logic       dpad_lock_reg,   dpad_lock_next;
    logic       buttons_lock_reg, buttons_lock_next;
    logic [1:0] player_reg,      player_next;
    logic [1:0] mode_reg,        mode_next;
    logic       wait_pulse_reg,  wait_pulse_next;
    logic       wait_rel_reg,    wait_rel_next;
    logic       wait_stop_reg,   wait_stop_next;
    logic [2:0] bit_cnt_reg,     bit_cnt_next;
    logic [BYTE_IDX_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [7:0] shift_reg,       shift_next;
    logic       store_we;

    logic [7:0] store_mem [PACKET_BYTES];
    logic [7:0] byte0_reg;
    logic [7:0] byte1_reg;
    logic [7:0] rd_byte_reg;

    logic [3:0] nibble_reg,      nibble_next;
    logic       accepted_reg,    accepted_next;
    logic [BYTE_IDX_W-1:0] idx_reg;

    // Receiver and player update for one select-line write
    always_comb
    begin
        logic       p14;
        logic       p15;
        logic [7:0] pad;
        logic       bit_val;

        p14 = in_data.select_dpad;
        p15 = in_data.select_buttons;

        dpad_lock_next    = dpad_lock_reg;
        buttons_lock_next = buttons_lock_reg;
        player_next       = player_reg;
        mode_next         = mode_reg;
        wait_pulse_next   = wait_pulse_reg;
        wait_rel_next     = wait_rel_reg;
        wait_stop_next    = wait_stop_reg;
        bit_cnt_next      = bit_cnt_reg;
        byte_cnt_next     = byte_cnt_reg;
        shift_next        = shift_reg;
        store_we          = 1'b0;
        accepted_next     = 1'b0;
        bit_val           = ~p15;

        // select-all advances the player
        if (p14 && p15 && !dpad_lock_reg && !buttons_lock_reg)
        begin
            dpad_lock_next    = 1'b1;
            buttons_lock_next = 1'b1;
            player_next       = player_reg + 2'd1;
            if (mode_reg == MODE_ONE)
                player_next = 2'd0;
            else if (mode_reg == MODE_TWO)
                player_next = {1'b0, player_next[0]};
        end

        // nibble driven back
        pad         = pads_reg[player_next];
        nibble_next = NIBBLE_ALL;
        if (p14 && p15)
            nibble_next = NIBBLE_ALL - {2'b00, player_next};
        if (!p14)
            nibble_next = nibble_next & pad[3:0];
        if (!p15)
            nibble_next = nibble_next & pad[7:4];

        if (!p14 && p15)
            dpad_lock_next = 1'b0;
        if (p14 && !p15)
            buttons_lock_next = 1'b0;

        // serial packet protocol
        if (!p14 && !p15)
        begin
            wait_pulse_next = 1'b0;
            byte_cnt_next   = '0;
            bit_cnt_next    = '0;
            wait_rel_next   = 1'b1;
            wait_stop_next  = 1'b0;
        end
        else if (!wait_pulse_reg)
        begin
            if (p14 && p15)
            begin
                wait_rel_next = 1'b0;
            end
            else
            begin
                // bit without release: abort
                if (wait_rel_reg)
                begin
                    wait_stop_next  = 1'b0;
                    wait_pulse_next = 1'b1;
                    bit_cnt_next    = '0;
                    byte_cnt_next   = '0;
                end
                wait_rel_next = 1'b1;
                if (wait_stop_next)
                begin
                    if (!p14 && p15)
                    begin
                        if (byte0_reg[7:3] == MULTI_CMD)
                        begin
                            mode_next   = byte1_reg[1:0];
                            player_next = PLAYER_AFTER_CMD;
                        end
                        accepted_next   = 1'b1;
                        wait_stop_next  = 1'b0;
                        wait_pulse_next = 1'b1;
                    end
                end
                else
                begin
                    shift_next   = {bit_val, shift_reg[7:1]};
                    bit_cnt_next = bit_cnt_next + 3'd1;
                    if (bit_cnt_next == 3'd0)
                    begin
                        store_we = 1'b1;
                        if (byte_cnt_next == LAST_BYTE_INDEX)
                        begin
                            byte_cnt_next  = '0;
                            wait_stop_next = 1'b1;
                        end
                        else
                        begin
                            byte_cnt_next = byte_cnt_next + BYTE_IDX_W'(1);
                        end
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAD_COUNT; i++)
                pads_reg[i] <= PAD_RESET;
            dpad_lock_reg    <= 1'b0;
            buttons_lock_reg <= 1'b0;
            player_reg       <= '0;
            mode_reg         <= MODE_ONE;
            wait_pulse_reg   <= 1'b1;
            wait_rel_reg     <= 1'b0;
            wait_stop_reg    <= 1'b0;
            bit_cnt_reg      <= '0;
            byte_cnt_reg     <= '0;
            shift_reg        <= '0;
            accepted_reg     <= 1'b0;
            idx_reg          <= '0;
        end
        else
        begin
            if (cfg_write)
                pads_reg[cfg_index] <= cfg_data;
            if (cmd.load)
            begin
                dpad_lock_reg    <= dpad_lock_next;
                buttons_lock_reg <= buttons_lock_next;
                player_reg       <= player_next;
                mode_reg         <= mode_next;
                wait_pulse_reg   <= wait_pulse_next;
                wait_rel_reg     <= wait_rel_next;
                wait_stop_reg    <= wait_stop_next;
                bit_cnt_reg      <= bit_cnt_next;
                byte_cnt_reg     <= byte_cnt_next;
                shift_reg        <= shift_next;
                accepted_reg     <= accepted_next;
                idx_reg          <= '0;
            end
            else if (cmd.next_byte)
            begin
                idx_reg <= idx_reg + BYTE_IDX_W'(1);
            end
        end
    end

    // Packet store, the two header bytes and the registered read port
    // (byte 0 is fetched on the load, each later byte on the step before it)
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            nibble_reg  <= nibble_next;
            rd_byte_reg <= store_mem[BYTE_IDX_W'(0)];
            if (store_we)
            begin
                store_mem[byte_cnt_reg] <= shift_next;
                if (byte_cnt_reg == BYTE_IDX_W'(0))
                    byte0_reg <= shift_next;
                if (byte_cnt_reg == BYTE_IDX_W'(1))
                    byte1_reg <= shift_next;
            end
        end
        else if (cmd.next_byte)
        begin
            rd_byte_reg <= store_mem[idx_reg + BYTE_IDX_W'(1)];
        end
    end

    // Result fields
    always_comb
    begin
        out_data.joypad_nibble  = nibble_reg;
        out_data.current_player = player_reg;
        out_data.player_mode    = mode_reg;
        out_data.byte_valid     = accepted_reg;
        out_data.packet_byte    = accepted_reg ? rd_byte_reg : 8'h00;
        out_data.byte_index     = accepted_reg ? idx_reg : '0;
        out_data.last           = !accepted_reg || (idx_reg == LAST_BYTE_INDEX);
        status.final_result     = out_data.last;
    end

endmodule

`default_nettype wire

// ----- hdl/jmpr_controller.sv -----
// Controller: takes one select-line write, then shows its result or packet burst.
// Depends on jmpr_pkg; commands jmpr_datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module jmpr_controller
    import jmpr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_stall && status.final_result)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall      = 1'b1;
        out_valid     = 1'b0;
        cmd.load      = 1'b0;
        cmd.next_byte = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_EMIT:
            begin
                out_valid     = 1'b1;
                cmd.next_byte = !out_stall && !status.final_result;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // One item in flight at a time
    a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted item produced no result");

    a_final_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && status.final_result) |=> !out_valid)
        else $error("results continue past the final transfer");

    a_step_only_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.next_byte |-> (out_valid && !status.final_result && !cmd.load))
        else $error("byte step outside a packet burst");

endmodule

`default_nettype wire
